@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros shared by the job queue modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// plain property checked every clock outside reset
`define CPJQ_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define CPJQ_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CPJQ_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CPJQ_ASSERT(name, clk, rst_n, prop, msg)
`define CPJQ_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define CPJQ_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ sv/cpjq_pkg.sv @@
// ----------------------------------------------------------------------------
// cpjq_pkg
// Types and constants of the class priority job queue.
// ----------------------------------------------------------------------------
package cpjq_pkg;

    localparam int FUNC_W  = 2;
    localparam int CLASS_W = 2;
    localparam int LIMIT_W = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // requester classes, lower code is served first
    localparam logic [CLASS_W-1:0] CLASS_DIRECTOR   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_ACCOUNTANT = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_CLERK      = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQUEUE = 2'd0,
        FUNC_POP     = 2'd1,
        FUNC_CLEAR   = 2'd2,
        FUNC_NOP     = 2'd3
    } t_func;

    // decoded control part of one queued operation
    typedef struct packed {
        t_func               func;
        logic [CLASS_W-1:0]  job_class;
    } t_op_ctl;

endpackage

@@ sv/cpjq_front.sv @@
// ----------------------------------------------------------------------------
// cpjq_front
// Accepts operations, decodes them and holds them in a two-entry queue
// until the back end takes them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpjq_front import cpjq_pkg::*; #(
    parameter int PRIO_WIDTH = 8,
    parameter int TAG_WIDTH  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [CLASS_W-1:0]    i_job_class,
    input  logic [PRIO_WIDTH-1:0] i_job_priority,
    input  logic [TAG_WIDTH-1:0]  i_job_tag,
    output logic                  o_op_valid,
    input  logic                  i_op_ready,
    output t_op_ctl               o_op_ctl,
    output logic [PRIO_WIDTH-1:0] o_op_priority,
    output logic [TAG_WIDTH-1:0]  o_op_tag
);

    t_op_ctl               r_ctl  [2];
    logic [PRIO_WIDTH-1:0] r_prio [2];
    logic [TAG_WIDTH-1:0]  r_tag  [2];
    logic                  r_wr_ptr, n_wr_ptr;
    logic                  r_rd_ptr, n_rd_ptr;
    logic [1:0]            r_cnt, n_cnt;
    logic                  push, pop;
    t_op_ctl               dec_ctl;

    // decode: class code three folds into clerk
    always_comb begin
        dec_ctl.func      = t_func'(i_func);
        dec_ctl.job_class = (i_job_class > CLASS_CLERK) ? CLASS_CLERK : i_job_class;
    end

    // queue handshake
    assign o_ready    = (r_cnt != 2'd2);
    assign push       = i_valid && o_ready;
    assign o_op_valid = (r_cnt != 2'd0);
    assign pop        = o_op_valid && i_op_ready;

    // pointer and count update
    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ctl[r_wr_ptr]  <= dec_ctl;
            r_prio[r_wr_ptr] <= i_job_priority;
            r_tag[r_wr_ptr]  <= i_job_tag;
        end
    end

    // head of queue
    assign o_op_ctl      = r_ctl[r_rd_ptr];
    assign o_op_priority = r_prio[r_rd_ptr];
    assign o_op_tag      = r_tag[r_rd_ptr];

    `CPJQ_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= 2'd2, "front queue count out of range")
    `CPJQ_ASSERT_IMP(a_ptr_empty, i_clk, i_rst_n, (r_cnt == 2'd0) || (r_cnt == 2'd2), r_wr_ptr == r_rd_ptr, "front queue pointers disagree with count")
    `CPJQ_ASSERT_NXT(a_push_only, i_clk, i_rst_n, push && !pop, r_cnt == $past(r_cnt) + 2'd1, "front queue lost a push")

endmodule

@@ sv/cpjq_back.sv @@
// ----------------------------------------------------------------------------
// cpjq_back
// Sorted entry array with per-entry compare and shift, plus the result
// register. Executes one operation per cycle while the result register is free or draining.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpjq_back import cpjq_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int PRIO_WIDTH = 8,
    parameter int TAG_WIDTH  = 16,
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [LIMIT_W-1:0]    i_limit,
    input  logic                  i_op_valid,
    output logic                  o_op_ready,
    input  t_op_ctl               i_op_ctl,
    input  logic [PRIO_WIDTH-1:0] i_op_priority,
    input  logic [TAG_WIDTH-1:0]  i_op_tag,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_accepted,
    output logic                  o_head_valid,
    output logic [CLASS_W-1:0]    o_head_class,
    output logic [PRIO_WIDTH-1:0] o_head_priority,
    output logic [TAG_WIDTH-1:0]  o_head_tag,
    output logic [CW-1:0]         o_fill_count,
    output logic                  o_is_full
);

    localparam int CMP_W = (CW > LIMIT_W) ? CW : LIMIT_W;

    logic [CLASS_W-1:0]    r_cls  [DEPTH];
    logic [PRIO_WIDTH-1:0] r_prio [DEPTH];
    logic [TAG_WIDTH-1:0]  r_tag  [DEPTH];
    logic [CW-1:0]         r_count, n_count;

    logic                  r_out_valid;
    logic                  r_out_acc, n_out_acc;
    logic                  r_out_hv, n_out_hv;
    logic [CLASS_W-1:0]    r_out_cls, n_out_cls;
    logic [PRIO_WIDTH-1:0] r_out_prio, n_out_prio;
    logic [TAG_WIDTH-1:0]  r_out_tag, n_out_tag;
    logic [CW-1:0]         r_out_fill;
    logic                  r_out_full, n_out_full;

    logic                  fire;
    logic                  full_now;
    logic                  ins_en, pop_en;
    logic [DEPTH-1:0]      after_new;
    logic [DEPTH-1:0]      after_prev;

    // result register free or draining
    assign o_op_ready = !r_out_valid || i_ready;
    assign fire       = i_op_valid && o_op_ready;

    // full when count reaches the limit or the physical depth
    assign full_now = (CMP_W'(r_count) >= CMP_W'(i_limit)) || (r_count == CW'(DEPTH));

    // operation execution
    always_comb begin
        ins_en     = 1'b0;
        pop_en     = 1'b0;
        n_count    = r_count;
        n_out_acc  = 1'b0;
        n_out_hv   = 1'b0;
        n_out_cls  = '0;
        n_out_prio = '0;
        n_out_tag  = '0;
        case (i_op_ctl.func)
            FUNC_ENQUEUE: begin
                if (!full_now) begin
                    ins_en    = fire;
                    n_count   = CW'(r_count + 1'b1);
                    n_out_acc = 1'b1;
                end
            end
            FUNC_POP: begin
                if (r_count != '0) begin
                    pop_en     = fire;
                    n_count    = CW'(r_count - 1'b1);
                    n_out_acc  = 1'b1;
                    n_out_hv   = 1'b1;
                    n_out_cls  = r_cls[0];
                    n_out_prio = r_prio[0];
                    n_out_tag  = r_tag[0];
                end
            end
            FUNC_CLEAR: begin
                n_count   = '0;
                n_out_acc = 1'b1;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out_full = (CMP_W'(n_count) >= CMP_W'(i_limit)) || (n_count == CW'(DEPTH));
    end

    // entries behind the new job in sort order form a tail of the valid run
    assign after_prev = after_new << 1;

    // entry cells: compare against the incoming key, then hold, shift or load
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [CLASS_W-1:0]    prev_cls, next_cls;
        logic [PRIO_WIDTH-1:0] prev_prio, next_prio;
        logic [TAG_WIDTH-1:0]  prev_tag, next_tag;

        assign after_new[i] = (CW'(i) < r_count) &&
            ((r_cls[i] > i_op_ctl.job_class) ||
             ((r_cls[i] == i_op_ctl.job_class) && (r_prio[i] < i_op_priority)));

        if (i == 0) begin : g_first
            assign prev_cls  = r_cls[i];
            assign prev_prio = r_prio[i];
            assign prev_tag  = r_tag[i];
        end else begin : g_mid
            assign prev_cls  = r_cls[i-1];
            assign prev_prio = r_prio[i-1];
            assign prev_tag  = r_tag[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign next_cls  = r_cls[i];
            assign next_prio = r_prio[i];
            assign next_tag  = r_tag[i];
        end else begin : g_body
            assign next_cls  = r_cls[i+1];
            assign next_prio = r_prio[i+1];
            assign next_tag  = r_tag[i+1];
        end

        always_ff @(posedge i_clk) begin
            if (ins_en) begin
                if (after_prev[i]) begin
                    r_cls[i]  <= prev_cls;
                    r_prio[i] <= prev_prio;
                    r_tag[i]  <= prev_tag;
                end else if (after_new[i] || (CW'(i) == r_count)) begin
                    r_cls[i]  <= i_op_ctl.job_class;
                    r_prio[i] <= i_op_priority;
                    r_tag[i]  <= i_op_tag;
                end
            end else if (pop_en) begin
                r_cls[i]  <= next_cls;
                r_prio[i] <= next_prio;
                r_tag[i]  <= next_tag;
            end
        end
    end

    // count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_count <= n_count;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_acc  <= n_out_acc;
            r_out_hv   <= n_out_hv;
            r_out_cls  <= n_out_cls;
            r_out_prio <= n_out_prio;
            r_out_tag  <= n_out_tag;
            r_out_fill <= n_count;
            r_out_full <= n_out_full;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_accepted      = r_out_acc;
    assign o_head_valid    = r_out_hv;
    assign o_head_class    = r_out_cls;
    assign o_head_priority = r_out_prio;
    assign o_head_tag      = r_out_tag;
    assign o_fill_count    = r_out_fill;
    assign o_is_full       = r_out_full;

    `CPJQ_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CW'(DEPTH), "entry count above depth")
    `CPJQ_ASSERT_IMP(a_fill_match, i_clk, i_rst_n, r_out_valid, r_out_fill == r_count, "reported fill count differs from entry count")
    `CPJQ_ASSERT_IMP(a_head_acc, i_clk, i_rst_n, r_out_valid && r_out_hv, r_out_acc, "head returned without acceptance")
    `CPJQ_ASSERT_NXT(a_ins_grow, i_clk, i_rst_n, ins_en, r_count == $past(r_count) + 1'b1, "accepted enqueue did not grow the queue")

endmodule

@@ sv/class_priority_job_queue.sv @@
// ----------------------------------------------------------------------------
// class_priority_job_queue: class-ordered sorted job queue
// Transactions pass the front queue and the result register; one per cycle
// sustained unless results stall, set by the compare-and-shift entry array.
// Synchronous active-low reset empties the queue and sets the limit to 16.
// ----------------------------------------------------------------------------
module class_priority_job_queue import cpjq_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int PRIO_WIDTH = 8,
    parameter int TAG_WIDTH  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [LIMIT_W-1:0]          i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [FUNC_W-1:0]           i_func,
    input  logic [CLASS_W-1:0]          i_job_class,
    input  logic [PRIO_WIDTH-1:0]       i_job_priority,
    input  logic [TAG_WIDTH-1:0]        i_job_tag,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_accepted,
    output logic                        o_head_valid,
    output logic [CLASS_W-1:0]          o_head_class,
    output logic [PRIO_WIDTH-1:0]       o_head_priority,
    output logic [TAG_WIDTH-1:0]        o_head_tag,
    output logic [$clog2(DEPTH+1)-1:0]  o_fill_count,
    output logic                        o_is_full
);

    logic [LIMIT_W-1:0]    r_queue_limit;
    logic                  op_valid, op_ready;
    t_op_ctl               op_ctl;
    logic [PRIO_WIDTH-1:0] op_priority;
    logic [TAG_WIDTH-1:0]  op_tag;

    // queue limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_queue_limit <= i_cfg_wdata;
        end
    end

    // accept and decode
    cpjq_front #(
        .PRIO_WIDTH (PRIO_WIDTH),
        .TAG_WIDTH  (TAG_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_job_class    (i_job_class),
        .i_job_priority (i_job_priority),
        .i_job_tag      (i_job_tag),
        .o_op_valid     (op_valid),
        .i_op_ready     (op_ready),
        .o_op_ctl       (op_ctl),
        .o_op_priority  (op_priority),
        .o_op_tag       (op_tag)
    );

    // sorted storage and results
    cpjq_back #(
        .DEPTH      (DEPTH),
        .PRIO_WIDTH (PRIO_WIDTH),
        .TAG_WIDTH  (TAG_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_limit         (r_queue_limit),
        .i_op_valid      (op_valid),
        .o_op_ready      (op_ready),
        .i_op_ctl        (op_ctl),
        .i_op_priority   (op_priority),
        .i_op_tag        (op_tag),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_accepted      (o_accepted),
        .o_head_valid    (o_head_valid),
        .o_head_class    (o_head_class),
        .o_head_priority (o_head_priority),
        .o_head_tag      (o_head_tag),
        .o_fill_count    (o_fill_count),
        .o_is_full       (o_is_full)
    );

endmodule

@@ tb/tb_class_priority_job_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_class_priority_job_queue
// Checks the sorted job queue against an in-bench copy of its ordering rules.
// Directed operations cover ordering, ties, empty and clear cases, then random
// fill and drain bursts run under several queue limits with random idling.
// ----------------------------------------------------------------------------
module tb_class_priority_job_queue import cpjq_pkg::*; ();

    localparam int QUEUE_DEPTH    = 16;
    localparam int PRIO_W         = 8;
    localparam int TAG_W          = 16;
    localparam int COUNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int QUEUE_LATENCY  = 2;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // one result transaction of the queue
    typedef struct packed {
        logic               accepted;
        logic               head_valid;
        logic [CLASS_W-1:0] head_class;
        logic [PRIO_W-1:0]  head_priority;
        logic [TAG_W-1:0]   head_tag;
        logic [COUNT_W-1:0] fill_count;
        logic               is_full;
    } t_queue_result;

    // sorted queue predictor and result checker
    class job_queue_scoreboard;
        logic [CLASS_W-1:0] slot_class [QUEUE_DEPTH];
        logic [PRIO_W-1:0]  slot_priority [QUEUE_DEPTH];
        logic [TAG_W-1:0]   slot_tag [QUEUE_DEPTH];
        int                 held;
        logic [LIMIT_W-1:0] limit;
        t_queue_result      awaited [$];
        int                 errors;

        function new();
            held   = 0;
            limit  = LIMIT_RESET;
            errors = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] value);
            limit = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // full while the count is at or above the limit clipped to the depth
        function bit at_limit();
            int eff;
            eff = (limit > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(limit);
            return held >= eff;
        endfunction

        // apply one accepted operation and queue the result it should give
        function void note_input(logic [FUNC_W-1:0] op, logic [CLASS_W-1:0] cls_in,
                                 logic [PRIO_W-1:0] prio, logic [TAG_W-1:0] tag);
            t_queue_result      r;
            logic [CLASS_W-1:0] cls;
            int                 pos;
            r   = '0;
            cls = (cls_in > CLASS_CLERK) ? CLASS_CLERK : cls_in;
            case (t_func'(op))
                FUNC_ENQUEUE: begin
                    if (!at_limit() && held < QUEUE_DEPTH) begin
                        // first entry of a later class or lower priority
                        pos = held;
                        for (int i = 0; i < held; i++) begin
                            if (pos == held && (slot_class[i] > cls ||
                                (slot_class[i] == cls && slot_priority[i] < prio)))
                                pos = i;
                        end
                        for (int i = held; i > pos; i--) begin
                            slot_class[i]    = slot_class[i-1];
                            slot_priority[i] = slot_priority[i-1];
                            slot_tag[i]      = slot_tag[i-1];
                        end
                        slot_class[pos]    = cls;
                        slot_priority[pos] = prio;
                        slot_tag[pos]      = tag;
                        held++;
                        r.accepted = 1'b1;
                    end
                end
                FUNC_POP: begin
                    if (held > 0) begin
                        r.accepted      = 1'b1;
                        r.head_valid    = 1'b1;
                        r.head_class    = slot_class[0];
                        r.head_priority = slot_priority[0];
                        r.head_tag      = slot_tag[0];
                        for (int i = 0; i + 1 < held; i++) begin
                            slot_class[i]    = slot_class[i+1];
                            slot_priority[i] = slot_priority[i+1];
                            slot_tag[i]      = slot_tag[i+1];
                        end
                        held--;
                    end
                end
                FUNC_CLEAR: begin
                    held       = 0;
                    r.accepted = 1'b1;
                end
                default: ;
            endcase
            r.fill_count = COUNT_W'(held);
            r.is_full    = at_limit();
            awaited.push_back(r);
        endfunction

        // compare one result transaction with the oldest expectation
        function void check_result(t_queue_result got);
            t_queue_result want;
            int            bad;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: acc=%0b hv=%0b cls=%0d pri=%0d tag=%h cnt=%0d full=%0b",
                             got.accepted, got.head_valid, got.head_class, got.head_priority,
                             got.head_tag, got.fill_count, got.is_full);
                return;
            end
            want = awaited.pop_front();
            bad  = 0;
            if (got.accepted !== want.accepted) bad++;
            if (got.head_valid !== want.head_valid) bad++;
            if (got.head_class !== want.head_class) bad++;
            if (got.head_priority !== want.head_priority) bad++;
            if (got.head_tag !== want.head_tag) bad++;
            if (got.fill_count !== want.fill_count) bad++;
            if (got.is_full !== want.is_full) bad++;
            if (bad != 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("mismatch exp: acc=%0b hv=%0b cls=%0d pri=%0d tag=%h cnt=%0d full=%0b",
                             want.accepted, want.head_valid, want.head_class,
                             want.head_priority, want.head_tag, want.fill_count, want.is_full);
                    $display("mismatch got: acc=%0b hv=%0b cls=%0d pri=%0d tag=%h cnt=%0d full=%0b",
                             got.accepted, got.head_valid, got.head_class, got.head_priority,
                             got.head_tag, got.fill_count, got.is_full);
                end
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [LIMIT_W-1:0]   i_cfg_wdata;
    logic                 i_valid;
    logic                 o_ready;
    logic [FUNC_W-1:0]    i_func;
    logic [CLASS_W-1:0]   i_job_class;
    logic [PRIO_W-1:0]    i_job_priority;
    logic [TAG_W-1:0]     i_job_tag;
    logic                 o_valid;
    logic                 i_ready;
    logic                 o_accepted;
    logic                 o_head_valid;
    logic [CLASS_W-1:0]   o_head_class;
    logic [PRIO_W-1:0]    o_head_priority;
    logic [TAG_W-1:0]     o_head_tag;
    logic [COUNT_W-1:0]   o_fill_count;
    logic                 o_is_full;

    job_queue_scoreboard  sb;
    bit                   steady;
    int                   quiet_cycles;

    class_priority_job_queue #(
        .DEPTH      (QUEUE_DEPTH),
        .PRIO_WIDTH (PRIO_W),
        .TAG_WIDTH  (TAG_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_job_class     (i_job_class),
        .i_job_priority  (i_job_priority),
        .i_job_tag       (i_job_tag),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_accepted      (o_accepted),
        .o_head_valid    (o_head_valid),
        .o_head_class    (o_head_class),
        .o_head_priority (o_head_priority),
        .o_head_tag      (o_head_tag),
        .o_fill_count    (o_fill_count),
        .o_is_full       (o_is_full)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // result side back-pressure
    always @(posedge i_clk) begin
        i_ready <= steady || ($urandom_range(99) >= 13);
    end

    // input and result transactions, input first so prediction leads
    always @(posedge i_clk) begin : monitor
        t_queue_result got;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_input(i_func, i_job_class, i_job_priority, i_job_tag);
            if (o_valid && i_ready) begin
                got = '{accepted: o_accepted, head_valid: o_head_valid,
                        head_class: o_head_class, head_priority: o_head_priority,
                        head_tag: o_head_tag, fill_count: o_fill_count,
                        is_full: o_is_full};
                sb.check_result(got);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // present one operation and hold it until accepted
    task automatic send_op(t_func op, logic [CLASS_W-1:0] cls,
                           logic [PRIO_W-1:0] prio, logic [TAG_W-1:0] tag);
        if (!steady && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= op;
        i_job_class    <= cls;
        i_job_priority <= prio;
        i_job_tag      <= tag;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // stop sending until every outstanding result is back
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (QUEUE_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] value);
        wait_results_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_limit(value);
    endtask

    // class three shows up now and then, it should sort as a clerk
    function automatic logic [CLASS_W-1:0] rand_class();
        return ($urandom_range(99) < 10) ? 2'd3 : CLASS_W'($urandom_range(2));
    endfunction

    // bias priorities to extremes and a narrow band so ties happen
    function automatic logic [PRIO_W-1:0] rand_prio();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) return '0;
        if (pick < 30) return '1;
        if (pick < 60) return PRIO_W'($urandom_range(3));
        return PRIO_W'($urandom);
    endfunction

    task automatic send_enqueue();
        send_op(FUNC_ENQUEUE, rand_class(), rand_prio(), TAG_W'($urandom));
    endtask

    // loose mix of all operations with junk in the ignored fields
    task automatic send_mixed_op();
        int   pick;
        t_func op;
        pick = $urandom_range(99);
        if (pick < 45)      op = FUNC_ENQUEUE;
        else if (pick < 85) op = FUNC_POP;
        else if (pick < 93) op = FUNC_CLEAR;
        else                op = FUNC_NOP;
        send_op(op, CLASS_W'($urandom), rand_prio(), TAG_W'($urandom));
    endtask

    // random phase: mostly fill then drain bursts, some mix and noise
    task automatic run_phase(int n_items);
        int sent;
        int pick;
        int fill;
        int pops;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            if (!paused && sent >= n_items / 2) begin
                wait_results_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                fill = $urandom_range(1, 18);
                pops = $urandom_range(fill / 2, fill + 2);
                repeat (fill) send_enqueue();
                repeat (pops) send_op(FUNC_POP, CLASS_W'($urandom), PRIO_W'($urandom),
                                      TAG_W'($urandom));
                sent += fill + pops;
            end else if (pick < 90) begin
                repeat (8) send_mixed_op();
                sent += 8;
            end else begin
                // broken burst cut short by a clear, then a stray no-op
                fill = $urandom_range(1, 6);
                repeat (fill) send_enqueue();
                send_op(FUNC_CLEAR, CLASS_W'($urandom), PRIO_W'($urandom), TAG_W'($urandom));
                send_op(FUNC_NOP, CLASS_W'($urandom), PRIO_W'($urandom), TAG_W'($urandom));
                sent += fill + 2;
            end
        end
    endtask

    // main sequence
    initial begin
        sb             = new();
        steady         = 1'b0;
        quiet_cycles   = 0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= LIMIT_RESET;
        i_valid        <= 1'b0;
        i_ready        <= 1'b0;
        i_func         <= FUNC_NOP;
        i_job_class    <= CLASS_DIRECTOR;
        i_job_priority <= '0;
        i_job_tag      <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue corner cases and an ignored no-op
        send_op(FUNC_POP,     CLASS_DIRECTOR,   8'h00, 16'h0000);
        send_op(FUNC_CLEAR,   CLASS_DIRECTOR,   8'h00, 16'h0000);
        send_op(FUNC_NOP,     2'd3,             8'hff, 16'hffff);
        // ordering by class then priority, class three and a tie
        send_op(FUNC_ENQUEUE, CLASS_CLERK,      8'h00, 16'h0000);
        send_op(FUNC_ENQUEUE, CLASS_DIRECTOR,   8'hff, 16'hffff);
        send_op(FUNC_ENQUEUE, CLASS_ACCOUNTANT, 8'h80, 16'h1234);
        send_op(FUNC_ENQUEUE, 2'd3,             8'hff, 16'h5555);
        send_op(FUNC_ENQUEUE, CLASS_ACCOUNTANT, 8'h80, 16'h4321);
        send_op(FUNC_ENQUEUE, CLASS_DIRECTOR,   8'h00, 16'haaaa);
        send_op(FUNC_ENQUEUE, CLASS_ACCOUNTANT, 8'h81, 16'h0f0f);
        // drain past empty, junk in the ignored fields
        repeat (8) send_op(FUNC_POP, 2'd3, 8'hff, 16'hffff);
        // tie then clear on a filled queue
        send_op(FUNC_ENQUEUE, CLASS_DIRECTOR,   8'h07, 16'h0001);
        send_op(FUNC_ENQUEUE, CLASS_DIRECTOR,   8'h07, 16'h0002);
        send_op(FUNC_CLEAR,   CLASS_CLERK,      8'h55, 16'h9999);
        send_op(FUNC_POP,     CLASS_DIRECTOR,   8'h00, 16'h0000);

        // limit sweep, one phase without any idling
        write_limit(5'd1);
        run_phase(120);
        write_limit(5'd0);
        run_phase(80);
        steady = 1'b1;
        write_limit(5'd31);
        run_phase(160);
        steady = 1'b0;
        write_limit(5'd17);
        run_phase(120);
        write_limit(5'd16);
        run_phase(160);

        // lower the limit under a populated queue
        send_op(FUNC_CLEAR, CLASS_DIRECTOR, 8'h00, 16'h0000);
        repeat (12) send_enqueue();
        write_limit(5'd4);
        run_phase(120);
        write_limit(5'd8);
        run_phase(120);
        repeat (2) begin
            write_limit(LIMIT_W'($urandom_range(31)));
            run_phase(120);
        end

        // let everything come back, then settle
        wait_results_drained();
        repeat (QUEUE_LATENCY + 8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
